// ===== hw/rtl/scma_pkg.sv =====
// ----------------------------------------------------------------------------
// scma_pkg
// Shared types and constants for the sparse coordinate-list matrix adder.
// ----------------------------------------------------------------------------
package scma_pkg;

   localparam int MAX_ENTRIES = 32;
   localparam int MAX_DIM     = 256;

   localparam int IDX_W    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
   localparam int DIM_W    = 9;
   localparam int ROW_W    = 8;
   localparam int COL_W    = 8;
   localparam int VAL_W    = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 2;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(MAX_ENTRIES);

   localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
   localparam logic [MODE_W-1:0] MODE_MERGE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_ENTRY    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_A = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_B = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_B = 2'd3;

   typedef struct packed {
      logic [ROW_W-1:0]        row;
      logic [COL_W-1:0]        col;
      logic signed [VAL_W-1:0] value;
   } entry_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
      logic step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic slot_free;
      logic step_last;
   } dp_status_type;

endpackage

// ===== hw/rtl/sparse_coo_matrix_add_top.sv =====
// ----------------------------------------------------------------------------
// sparse_coo_matrix_add_top
// Sparse matrix adder over two coordinate lists, merged in row-major order.
// ----------------------------------------------------------------------------
// Usage:
//   csr_*  : writes rows_a, cols_a, rows_b, cols_b (index 0..3); always ready.
//            Write only while no merge is in flight.
//   req_*  : one item per handshake. Mode 0/1 appends an entry to list A/B
//            (dropped once 32 entries are held); mode 2 starts a merge.
//            Loads are accepted back to back while idle and produce no result.
//   rsp_*  : merge results in row-then-column order; rsp_last marks the
//            final item of a merge. Status 1 = both lists empty, status 2 =
//            dimension mismatch, each as a single item.
// Merge: an accepted merge item moves the controller into its run state;
//   each step then loads one result into the output register, one result per
//   cycle while the receiver takes them (count_a + count_b results at most).
//   req_ready is low until the final result is in the output register.
// Reset clears the list counts and sets all dimensions to 256. A stalled
//   receiver holds the output register and pauses the walk.
// ----------------------------------------------------------------------------
module sparse_coo_matrix_add_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [scma_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [scma_pkg::DIM_W-1:0]           csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [scma_pkg::MODE_W-1:0]          req_mode,
   input  logic [scma_pkg::ROW_W-1:0]           req_row,
   input  logic [scma_pkg::COL_W-1:0]           req_col,
   input  logic signed [scma_pkg::VAL_W-1:0]    req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [scma_pkg::STATUS_W-1:0]        rsp_status,
   output logic [scma_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [scma_pkg::COL_W-1:0]           rsp_out_col,
   output logic signed [scma_pkg::VAL_W-1:0]    rsp_out_value,
   output logic                                 rsp_last
);
   import scma_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   scma_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .cmd       (cmd),
      .status    (status)
   );

   scma_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_row       (req_row),
      .req_col       (req_col),
      .req_value     (req_value),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_out_row   (rsp_out_row),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_value (rsp_out_value),
      .rsp_last      (rsp_last)
   );

endmodule

// ===== hw/rtl/scma_ctrl.sv =====
// ----------------------------------------------------------------------------
// scma_ctrl
// Controller: accepts items, issues loads and sequences the merge walk.
// ----------------------------------------------------------------------------
module scma_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [scma_pkg::MODE_W-1:0]  req_mode,
   output scma_pkg::ctrl_cmd_type       cmd,
   input  scma_pkg::dp_status_type      status
);
   import scma_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_RUN  = 2'b10
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      cmd.load_a = accept && (req_mode == MODE_LOAD_A);
      cmd.load_b = accept && (req_mode == MODE_LOAD_B);
      cmd.step   = (state_ff == S_RUN) && status.slot_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_mode == MODE_MERGE)) begin
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (cmd.step && status.step_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hw/rtl/scma_dp.sv =====
// ----------------------------------------------------------------------------
// scma_dp
// Datapath: dimension registers, both entry lists, merge pointers, adder
// and the result register.
// ----------------------------------------------------------------------------
module scma_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   input  logic [scma_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [scma_pkg::DIM_W-1:0]           csr_data,
   input  logic [scma_pkg::ROW_W-1:0]           req_row,
   input  logic [scma_pkg::COL_W-1:0]           req_col,
   input  logic signed [scma_pkg::VAL_W-1:0]    req_value,
   input  scma_pkg::ctrl_cmd_type               cmd,
   output scma_pkg::dp_status_type              status,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [scma_pkg::STATUS_W-1:0]        rsp_status,
   output logic [scma_pkg::ROW_W-1:0]           rsp_out_row,
   output logic [scma_pkg::COL_W-1:0]           rsp_out_col,
   output logic signed [scma_pkg::VAL_W-1:0]    rsp_out_value,
   output logic                                 rsp_last
);
   import scma_pkg::*;

   logic [DIM_W-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;

   entry_type list_a_ff [MAX_ENTRIES];
   entry_type list_b_ff [MAX_ENTRIES];

   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic [CNT_W-1:0] idx_a_ff, idx_a_in;
   logic [CNT_W-1:0] idx_b_ff, idx_b_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   entry_type               rsp_ent_ff, rsp_ent_in;
   logic                    rsp_last_ff, rsp_last_in;

   entry_type        ent_a, ent_b;
   logic             have_a, have_b;
   logic             mismatch, empty;
   logic             a_lt, a_eq;
   logic             take_a, take_b;
   logic [CNT_W-1:0] idx_a_nxt, idx_b_nxt;
   logic             walk_last;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff <= DIM_RESET;
         cols_a_ff <= DIM_RESET;
         rows_b_ff <= DIM_RESET;
         cols_b_ff <= DIM_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROWS_A: rows_a_ff <= csr_data;
            CSR_COLS_A: cols_a_ff <= csr_data;
            CSR_ROWS_B: rows_b_ff <= csr_data;
            CSR_COLS_B: cols_b_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // entry lists
   always_ff @(posedge clock) begin
      if (cmd.load_a && (count_a_ff < CNT_MAX)) begin
         list_a_ff[count_a_ff[IDX_W-1:0]] <= '{row: req_row, col: req_col, value: req_value};
      end
      if (cmd.load_b && (count_b_ff < CNT_MAX)) begin
         list_b_ff[count_b_ff[IDX_W-1:0]] <= '{row: req_row, col: req_col, value: req_value};
      end
   end

   // merge step
   always_comb begin
      ent_a    = list_a_ff[idx_a_ff[IDX_W-1:0]];
      ent_b    = list_b_ff[idx_b_ff[IDX_W-1:0]];
      have_a   = idx_a_ff < count_a_ff;
      have_b   = idx_b_ff < count_b_ff;
      mismatch = (rows_a_ff != rows_b_ff) || (cols_a_ff != cols_b_ff);
      empty    = (count_a_ff == '0) && (count_b_ff == '0);
      a_lt     = {ent_a.row, ent_a.col} < {ent_b.row, ent_b.col};
      a_eq     = {ent_a.row, ent_a.col} == {ent_b.row, ent_b.col};

      take_a = 1'b0;
      take_b = 1'b0;
      if (have_a && have_b) begin
         take_a = a_lt || a_eq;
         take_b = !a_lt;
      end else if (have_a) begin
         take_a = 1'b1;
      end else begin
         take_b = 1'b1;
      end

      idx_a_nxt = idx_a_ff + CNT_W'(take_a);
      idx_b_nxt = idx_b_ff + CNT_W'(take_b);
      walk_last = (idx_a_nxt >= count_a_ff) && (idx_b_nxt >= count_b_ff);

      rsp_status_in = ST_ENTRY;
      rsp_ent_in    = take_a ? ent_a : ent_b;
      rsp_last_in   = walk_last;
      if (mismatch) begin
         rsp_status_in = ST_MISMATCH;
         rsp_ent_in    = '0;
         rsp_last_in   = 1'b1;
      end else if (empty) begin
         rsp_status_in = ST_EMPTY;
         rsp_ent_in    = '0;
         rsp_last_in   = 1'b1;
      end else if (take_a && take_b) begin
         rsp_ent_in.value = ent_a.value + ent_b.value;
      end

      status.slot_free = !rsp_valid_ff || rsp_ready;
      status.step_last = rsp_last_in;
   end

   always_comb begin
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      idx_a_in     = idx_a_ff;
      idx_b_in     = idx_b_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_a && (count_a_ff < CNT_MAX)) begin
         count_a_in = count_a_ff + CNT_W'(1);
      end
      if (cmd.load_b && (count_b_ff < CNT_MAX)) begin
         count_b_in = count_b_ff + CNT_W'(1);
      end
      if (cmd.step) begin
         rsp_valid_in = 1'b1;
         if (rsp_last_in) begin
            count_a_in = '0;
            count_b_in = '0;
            idx_a_in   = '0;
            idx_b_in   = '0;
         end else begin
            idx_a_in = idx_a_nxt;
            idx_b_in = idx_b_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         idx_a_ff     <= '0;
         idx_b_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         idx_a_ff     <= idx_a_in;
         idx_b_ff     <= idx_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step) begin
         rsp_status_ff <= rsp_status_in;
         rsp_ent_ff    <= rsp_ent_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_out_row   = rsp_ent_ff.row;
   assign rsp_out_col   = rsp_ent_ff.col;
   assign rsp_out_value = rsp_ent_ff.value;
   assign rsp_last      = rsp_last_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_a_ff <= CNT_MAX) && (count_b_ff <= CNT_MAX))
      else $error("list count beyond capacity");

   a_special_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != ST_ENTRY)) |-> rsp_last_ff)
      else $error("empty or mismatch result without last");

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && rsp_last_in) |=>
         (count_a_ff == '0) && (count_b_ff == '0) && (idx_a_ff == '0) && (idx_b_ff == '0))
      else $error("lists not cleared after final result");

endmodule
